### rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner: register
// indexes, result status codes, the item, configuration and result structs.
// ----------------------------------------------------------------------------
package wbps_pkg;

   // Fixed field widths
   localparam int BYTE_BITS           = 8;
   localparam int PATTERN_LIMIT       = 16;
   localparam int LEN_M1_BITS         = 4;
   localparam int LENGTH_BITS         = 5;
   localparam int CSR_DATA_BITS       = 64;
   localparam int CSR_INDEX_BITS      = 2;
   localparam int STATUS_BITS         = 2;
   localparam int RESULT_OFFSET_BITS  = 32;

   // Parameter defaults
   localparam int DEFAULT_PATTERN_MAX = 16;
   localparam int DEFAULT_OFFSET_BITS = 32;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_WILDCARD_MASK  = 2'd2,
      CSR_PATTERN_LENGTH = 2'd3
   } csr_index_type;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_NONE      = 2'd0,
      STATUS_MATCH     = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } scan_status_type;

   // One input item
   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 region_start;
      logic                 region_end;
   } item_type;

   // Pattern aligned to byte age: entry a is compared with the byte a steps old
   typedef struct packed {
      logic [PATTERN_LIMIT-1:0][BYTE_BITS-1:0] align_byte;
      logic [PATTERN_LIMIT-1:0]                align_wild;
      logic [LEN_M1_BITS-1:0]                  len_m1;
   } scan_cfg_type;

   // One result item
   typedef struct packed {
      scan_status_type                scan_status;
      logic [RESULT_OFFSET_BITS-1:0]  match_offset;
   } result_type;

endpackage

### rtl/wbps_csr.sv
// ----------------------------------------------------------------------------
// wbps_csr
// Configuration registers. Clamps the pattern length and presents the
// pattern reordered by byte age, so the scanner compares fixed window taps.
// ----------------------------------------------------------------------------
module wbps_csr #(
   parameter int PATTERN_MAX = wbps_pkg::DEFAULT_PATTERN_MAX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wbps_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output wbps_pkg::scan_cfg_type              cfg
);
   import wbps_pkg::*;

   logic [CSR_DATA_BITS-1:0] pat_low_ff, pat_low_in;
   logic [CSR_DATA_BITS-1:0] pat_high_ff, pat_high_in;
   logic [PATTERN_LIMIT-1:0] wild_ff, wild_in;
   logic [LENGTH_BITS-1:0]   length_ff, length_in;

   logic [PATTERN_LIMIT-1:0][BYTE_BITS-1:0] pat_bytes;
   logic [LEN_M1_BITS-1:0]                  len_m1;
   logic [LEN_M1_BITS-1:0]                  pos;

   // Writes are always taken
   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      wild_in     = wild_ff;
      length_in   = length_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pat_low_in  = csr_wdata;
            CSR_PATTERN_HIGH:   pat_high_in = csr_wdata;
            CSR_WILDCARD_MASK:  wild_in     = csr_wdata[PATTERN_LIMIT-1:0];
            CSR_PATTERN_LENGTH: length_in   = csr_wdata[LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         wild_ff     <= '0;
         length_ff   <= LENGTH_BITS'(1);
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         wild_ff     <= wild_in;
         length_ff   <= length_in;
      end
   end

   // Clamp length: zero acts as one, anything above the window as the maximum
   always_comb begin
      if (length_ff == '0) begin
         len_m1 = '0;
      end else if (length_ff > LENGTH_BITS'(PATTERN_MAX)) begin
         len_m1 = LEN_M1_BITS'(PATTERN_MAX - 1);
      end else begin
         len_m1 = LEN_M1_BITS'(length_ff - LENGTH_BITS'(1));
      end
   end

   assign pat_bytes = {pat_high_ff, pat_low_ff};

   // Reorder by age: age a pairs with pattern position len_m1 - a;
   // ages beyond the pattern become wildcards
   always_comb begin
      pos = '0;
      for (int a = 0; a < PATTERN_LIMIT; a++) begin
         pos = len_m1 - LEN_M1_BITS'(a);
         cfg.align_byte[a] = pat_bytes[pos];
         cfg.align_wild[a] = (LEN_M1_BITS'(a) > len_m1) || wild_ff[pos];
      end
      cfg.len_m1 = len_m1;
   end

endmodule

### rtl/wbps_scan.sv
// ----------------------------------------------------------------------------
// wbps_scan
// Byte window, region offset counter and found latch, with the parallel
// window compare that forms the result for the item in the input register.
// ----------------------------------------------------------------------------
module wbps_scan #(
   parameter int PATTERN_MAX = wbps_pkg::DEFAULT_PATTERN_MAX,
   parameter int OFFSET_BITS = wbps_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  wbps_pkg::item_type     item,
   input  wbps_pkg::scan_cfg_type cfg,
   output wbps_pkg::result_type   result
);
   import wbps_pkg::*;

   localparam int WINDOW_DEPTH = PATTERN_MAX - 1;
   localparam int WIDE_BITS    = (OFFSET_BITS > RESULT_OFFSET_BITS) ?
                                 OFFSET_BITS : RESULT_OFFSET_BITS;

   logic [BYTE_BITS-1:0]   window_ff [WINDOW_DEPTH];
   logic [BYTE_BITS-1:0]   window_in [WINDOW_DEPTH];
   logic [OFFSET_BITS-1:0] bytes_seen_ff, bytes_seen_in;
   logic                   found_ff, found_in;

   logic [BYTE_BITS-1:0]   hist [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] pos_ok;
   logic [OFFSET_BITS-1:0] idx;
   logic [OFFSET_BITS-1:0] len_ext;
   logic [OFFSET_BITS-1:0] offset_diff;
   logic [WIDE_BITS-1:0]   offset_wide;
   logic                   found_eff;
   logic                   hit;

   // Region start restarts the count and the latch; old window bytes are
   // out of reach because a tap is used only once the region covers it
   assign idx       = item.region_start ? '0 : bytes_seen_ff;
   assign found_eff = found_ff && !item.region_start;
   assign len_ext   = OFFSET_BITS'(cfg.len_m1);

   // Gather the current byte and the window taps by age
   always_comb begin
      hist[0] = item.data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         hist[k] = window_ff[k-1];
      end
   end

   // Compare every tap with its aligned pattern byte
   always_comb begin
      for (int a = 0; a < PATTERN_MAX; a++) begin
         pos_ok[a] = cfg.align_wild[a] || (hist[a] == cfg.align_byte[a]);
      end
   end

   assign hit = !found_eff && (idx >= len_ext) && (&pos_ok);

   // Offset of the first matched byte, low bits reported
   assign offset_diff = idx - len_ext;
   assign offset_wide = WIDE_BITS'(offset_diff);

   // Form the result
   always_comb begin
      result.match_offset = '0;
      if (hit) begin
         result.scan_status  = STATUS_MATCH;
         result.match_offset = offset_wide[RESULT_OFFSET_BITS-1:0];
      end else if (!found_eff && item.region_end) begin
         result.scan_status = STATUS_NOT_FOUND;
      end else begin
         result.scan_status = STATUS_NONE;
      end
   end

   // Next state: shift the window, saturate the count, latch a match
   always_comb begin
      window_in[0] = item.data_byte;
      for (int k = 1; k < WINDOW_DEPTH; k++) begin
         window_in[k] = window_ff[k-1];
      end
      bytes_seen_in = (&idx) ? idx : idx + OFFSET_BITS'(1);
      found_in      = found_eff || hit;
   end

   // Window bytes need no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         found_ff      <= 1'b0;
      end else if (advance) begin
         bytes_seen_ff <= bytes_seen_in;
         found_ff      <= found_in;
      end
   end

`ifndef SYNTHESIS
   a_match_sets_latch: assert property (@(posedge clock) disable iff (reset)
      advance && (result.scan_status == STATUS_MATCH) |=> found_ff)
      else $error("match reported but found latch not set");

   a_quiet_after_match: assert property (@(posedge clock) disable iff (reset)
      advance && found_ff && !item.region_start |-> result.scan_status == STATUS_NONE)
      else $error("status reported after a match in the same region");

   a_start_restarts_count: assert property (@(posedge clock) disable iff (reset)
      advance && item.region_start |=> bytes_seen_ff == OFFSET_BITS'(1))
      else $error("region start did not restart the byte count");
`endif

endmodule

### rtl/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Scans a byte stream for a pattern of up to PATTERN_MAX bytes with
// wildcard positions and reports the offset of the first match per region.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one region byte per transfer, with region start and end flags.
//            A transfer happens on a clock edge with req_valid high and
//            req_stall low.
//   rsp_*  : exactly one result per input byte, in order: status none,
//            match (with the offset of the first matched byte) or not found.
//   csr_*  : register writes, index 0..3: pattern low, pattern high,
//            wildcard mask, pattern length. Always ready; write only while
//            no byte is in flight.
// Timing: a byte is held in the input register, the window compare
//   runs from there into the result register, and rsp_valid rises once the
//   byte has moved on from the input register into the result register.
//   Throughput is one byte per cycle while rsp_stall is low.
// Reset: clears the registers to their defaults, the byte count and found
//   latch, and empties both pipeline registers.
// Stall: a stalled result holds; the input register still takes one byte
//   while the result register is held, then req_stall rises until
//   rsp_stall drops.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
   parameter int PATTERN_MAX = wbps_pkg::DEFAULT_PATTERN_MAX,
   parameter int OFFSET_BITS = wbps_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [wbps_pkg::BYTE_BITS-1:0]          req_data_byte,
   input  logic                                    req_region_start,
   input  logic                                    req_region_end,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [wbps_pkg::STATUS_BITS-1:0]        rsp_scan_status,
   output logic [wbps_pkg::RESULT_OFFSET_BITS-1:0] rsp_match_offset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [wbps_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import wbps_pkg::*;

   scan_cfg_type cfg;
   result_type   result;

   logic         in_valid_ff, in_valid_in;
   item_type     in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   result_type   out_result_ff;
   logic         advance;
   logic         accept;

   wbps_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wbps_scan #(
      .PATTERN_MAX (PATTERN_MAX),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Move the held byte on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Input register
   always_comb begin
      in_valid_in = accept || (in_valid_ff && !advance);
      in_item_in  = in_item_ff;
      if (accept) begin
         in_item_in.data_byte    = req_data_byte;
         in_item_in.region_start = req_region_start;
         in_item_in.region_end   = req_region_end;
      end
   end

   // Result register: hold while stalled
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_scan_status  = out_result_ff.scan_status;
   assign rsp_match_offset = out_result_ff.match_offset;

`ifndef SYNTHESIS
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced byte produced no result");

   a_full_pipe_stalls: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while both stages are blocked");

   a_accept_loads_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted byte not held in the input register");
`endif

endmodule

### bench/wbps_scan_checker.sv
// ----------------------------------------------------------------------------
// wbps_scan_checker
// Watches the register, request and result channels of the wildcard byte
// pattern scanner. Keeps its own copy of the registers, the byte window, the
// region byte count and the found latch. Predicts the result of every byte
// transfer and compares each result transfer, field by field, with the
// oldest prediction.
// ----------------------------------------------------------------------------
module wbps_scan_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic [wbps_pkg::BYTE_BITS-1:0]          req_data_byte,
   input  logic                                    req_region_start,
   input  logic                                    req_region_end,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic [wbps_pkg::STATUS_BITS-1:0]        rsp_scan_status,
   input  logic [wbps_pkg::RESULT_OFFSET_BITS-1:0] rsp_match_offset,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [wbps_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output int                                      fail_count,
   output int                                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import wbps_pkg::*;

   localparam int WINDOW_DEPTH = PATTERN_LIMIT - 1;

   // Register copy
   logic [CSR_DATA_BITS-1:0]      pattern_low;
   logic [CSR_DATA_BITS-1:0]      pattern_high;
   logic [PATTERN_LIMIT-1:0]      wild_mask;
   logic [LENGTH_BITS-1:0]        pattern_len;

   // Scan state
   logic [BYTE_BITS-1:0]          recent_bytes [WINDOW_DEPTH];
   logic [RESULT_OFFSET_BITS-1:0] region_bytes;
   logic                          found_latch;

   result_type                    pending_scans [$];
   int                            mismatches = 0;
   int                            queued = 0;

   assign fail_count    = mismatches;
   assign pending_count = queued;

   // Clamp the programmed length into 1..PATTERN_LIMIT
   function automatic int used_length();
      if (pattern_len == 0) begin
         return 1;
      end
      if (pattern_len > PATTERN_LIMIT) begin
         return PATTERN_LIMIT;
      end
      return int'(pattern_len);
   endfunction

   // Advance the scan state by one byte and return its result
   function automatic result_type scan_next_byte(input item_type it);
      int                   len;
      int                   age;
      logic [BYTE_BITS-1:0] seen;
      logic [BYTE_BITS-1:0] want;
      logic                 hit;
      result_type           res;
      len = used_length();
      if (it.region_start) begin
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            recent_bytes[k] = '0;
         end
         region_bytes = '0;
         found_latch  = 1'b0;
      end
      res.scan_status  = STATUS_NONE;
      res.match_offset = '0;

      // Compare the newest len bytes, oldest against pattern position 0
      if (!found_latch && region_bytes >= RESULT_OFFSET_BITS'(len - 1)) begin
         hit = 1'b1;
         for (int p = 0; p < len; p++) begin
            age  = len - 1 - p;
            seen = (age == 0) ? it.data_byte : recent_bytes[age - 1];
            want = (p < 8) ? pattern_low[8*p +: 8] : pattern_high[8*(p-8) +: 8];
            if (!wild_mask[p] && seen != want) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            found_latch      = 1'b1;
            res.scan_status  = STATUS_MATCH;
            res.match_offset = region_bytes - RESULT_OFFSET_BITS'(len - 1);
         end
      end
      if (res.scan_status == STATUS_NONE && !found_latch && it.region_end) begin
         res.scan_status = STATUS_NOT_FOUND;
      end

      // Shift the window and count the byte, saturating
      for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
         recent_bytes[k] = recent_bytes[k - 1];
      end
      recent_bytes[0] = it.data_byte;
      if (region_bytes != '1) begin
         region_bytes = region_bytes + 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      item_type   it;
      result_type want;
      result_type pred;
      if (reset) begin
         pattern_low  = '0;
         pattern_high = '0;
         wild_mask    = '0;
         pattern_len  = LENGTH_BITS'(1);
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            recent_bytes[k] = '0;
         end
         region_bytes = '0;
         found_latch  = 1'b0;
         pending_scans.delete();
      end else begin
         // Track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LOW:    pattern_low  = csr_wdata;
               CSR_PATTERN_HIGH:   pattern_high = csr_wdata;
               CSR_WILDCARD_MASK:  wild_mask    = csr_wdata[PATTERN_LIMIT-1:0];
               CSR_PATTERN_LENGTH: pattern_len  = csr_wdata[LENGTH_BITS-1:0];
               default: ;
            endcase
         end

         // Predict each byte transfer before matching results, so a result in
         // the same cycle still finds its prediction
         if (req_valid && !req_stall) begin
            it.data_byte    = req_data_byte;
            it.region_start = req_region_start;
            it.region_end   = req_region_end;
            pred = scan_next_byte(it);
            pending_scans.insert(pending_scans.size(), pred);
         end

         // Compare each result transfer with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_scans.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d offset %0d",
                        $time, rsp_scan_status, rsp_match_offset);
               mismatches++;
            end else begin
               want = pending_scans.pop_front();
               if (want.scan_status !== rsp_scan_status) begin
                  $display("%0t: scan_status mismatch, expected %0d, actual %0d",
                           $time, want.scan_status, rsp_scan_status);
                  mismatches++;
               end
               if (want.match_offset !== rsp_match_offset) begin
                  $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                           $time, want.match_offset, rsp_match_offset);
                  mismatches++;
               end
            end
         end
      end
      queued = pending_scans.size();
   end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the wildcard byte pattern scanner with directed regions and then
// random regions that carry planted, broken and absent pattern copies, under
// a series of pattern settings. Sender bursts and receiver stalls vary over
// the run. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wbps_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 60;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 150;
   localparam int REGION_MAX   = 160;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [BYTE_BITS-1:0]          req_data_byte;
   logic                          req_region_start;
   logic                          req_region_end;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [STATUS_BITS-1:0]        rsp_scan_status;
   logic [RESULT_OFFSET_BITS-1:0] rsp_match_offset;
   logic                          csr_valid;
   logic                          csr_ready;
   csr_index_type                 csr_index;
   logic [CSR_DATA_BITS-1:0]      csr_wdata;

   int                            fail_count;
   int                            pending_count;
   int                            cycle_count = 0;

   // Pattern as the stimulus sees it, used to plant copies in the regions
   logic [BYTE_BITS-1:0]          plant_bytes [PATTERN_LIMIT];
   logic [PATTERN_LIMIT-1:0]      plant_wild = '0;
   int                            plant_len = 1;

   int                            items_sent = 0;
   int                            burst_left = 0;
   int                            hold_requests = 0;
   int                            hold_served = 0;

   wildcard_byte_pattern_scanner DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_region_start (req_region_start),
      .req_region_end   (req_region_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scan_status  (rsp_scan_status),
      .rsp_match_offset (rsp_match_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   wbps_scan_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_region_start (req_region_start),
      .req_region_end   (req_region_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scan_status  (rsp_scan_status),
      .rsp_match_offset (rsp_match_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // Clock generation
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[wildcard_byte_pattern_scanner] ERROR");
         $finish;
      end
   end

   // Result side: stall on a changing pattern, with long hold-offs on request
   initial begin : result_sink
      int mode;
      int mode_left;
      mode      = 0;
      mode_left = 0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(40, 250);
            end
            mode_left--;
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 3) == 0);
               2: rsp_stall = ($urandom_range(0, 9) < 6);
               default: rsp_stall = ~rsp_stall;
            endcase
            @(negedge clock);
         end
      end
   end

   // Mostly bytes the patterns use, so accidental matches happen too
   function automatic logic [BYTE_BITS-1:0] pick_byte();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hFF;
         2, 3: return 8'h41 + BYTE_BITS'($urandom_range(0, 3));
         default: return BYTE_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one byte within the current burst; hold it until the transfer
   task automatic send_byte(input logic [BYTE_BITS-1:0] data, input logic first,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid        = 1'b1;
      req_data_byte    = data;
      req_region_start = first;
      req_region_end   = last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // Drop valid and wait for every outstanding result
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Program all four registers while idle and mirror them for planting
   task automatic apply_config(input logic [CSR_DATA_BITS-1:0] low,
                               input logic [CSR_DATA_BITS-1:0] high,
                               input logic [PATTERN_LIMIT-1:0] wild,
                               input logic [LENGTH_BITS-1:0]   len);
      wait_idle();
      write_reg(CSR_PATTERN_LOW, low);
      write_reg(CSR_PATTERN_HIGH, high);
      write_reg(CSR_WILDCARD_MASK, CSR_DATA_BITS'(wild));
      write_reg(CSR_PATTERN_LENGTH, CSR_DATA_BITS'(len));
      csr_valid = 1'b0;
      for (int k = 0; k < 8; k++) begin
         plant_bytes[k]     = low[8*k +: 8];
         plant_bytes[k + 8] = high[8*k +: 8];
      end
      plant_wild = wild;
      plant_len  = (len == 0) ? 1 : (len > PATTERN_LIMIT) ? PATTERN_LIMIT : int'(len);
   endtask

   // One region: random body, usually a planted copy, sometimes broken, with
   // occasional missing end, restart in the middle or trailing bytes
   task automatic send_region();
      logic [BYTE_BITS-1:0] body [REGION_MAX];
      int                   rlen;
      int                   at;
      int                   pos;
      int                   extra;
      logic                 put_end;
      logic                 first;
      rlen = ($urandom_range(0, 11) == 0) ? $urandom_range(40, REGION_MAX)
                                          : $urandom_range(1, 36);
      for (int k = 0; k < rlen; k++) begin
         body[k] = pick_byte();
      end
      if (rlen >= plant_len && $urandom_range(0, 9) < 8) begin
         at = $urandom_range(0, rlen - plant_len);
         for (int k = 0; k < plant_len; k++) begin
            body[at + k] = plant_wild[k] ? pick_byte() : plant_bytes[k];
         end
         if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, plant_len - 1);
            body[at + pos] = ~body[at + pos];
         end
      end
      put_end = ($urandom_range(0, 9) != 0);
      for (int k = 0; k < rlen; k++) begin
         first = (k == 0) || ($urandom_range(0, 149) == 0);
         send_byte(body[k], first, put_end && (k == rlen - 1));
      end
      // Continue the region past its end
      if ($urandom_range(0, 9) == 0) begin
         extra = $urandom_range(1, 6);
         repeat (extra) send_byte(pick_byte(), 1'b0, $urandom_range(0, 2) == 0);
      end
   endtask

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0]  low;
      logic [CSR_DATA_BITS-1:0]  high;
      logic [PATTERN_LIMIT-1:0]  wild;
      logic [LENGTH_BITS-1:0]    len;
      int                        phase_goal;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_region_start = 1'b0;
      req_region_end   = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_PATTERN_LOW;
      csr_wdata        = '0;
      for (int k = 0; k < PATTERN_LIMIT; k++) begin
         plant_bytes[k] = '0;
      end
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Reset pattern: one zero byte. Match, then quiet after the match,
      // continuation, match on a start-and-end byte, miss on all-ones
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);

      // Zeros then 'A': cleared window must not match a short region
      apply_config(64'h0000_0000_4100_0000, 64'h0, 16'h0000, 5'd4);
      send_byte(8'h41, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h41, 1'b0, 1'b1);
      send_byte(8'h41, 1'b0, 1'b0);
      send_byte(8'h42, 1'b0, 1'b1);
      // Not found, then not found again after the end
      send_byte(8'h10, 1'b1, 1'b1);
      send_byte(8'h11, 1'b0, 1'b1);

      // Two bytes with wildcard bits set only above the length
      apply_config(64'h0000_0000_0000_CDAB, '1, 16'hFFFC, 5'd2);
      send_byte(8'hAB, 1'b1, 1'b0);
      send_byte(8'hCD, 1'b0, 1'b1);
      send_byte(8'hCD, 1'b1, 1'b0);
      send_byte(8'hAB, 1'b0, 1'b0);
      send_byte(8'hCD, 1'b0, 1'b1);

      // Length zero acts as one
      apply_config(64'h0000_0000_0000_00AB, 64'h0, 16'h0000, 5'd0);
      send_byte(8'hAB, 1'b1, 1'b1);
      send_byte(8'h00, 1'b1, 1'b1);

      // Random phases, extremes first
      for (int phase = 0; phase < PHASES; phase++) begin
         for (int k = 0; k < 8; k++) begin
            low[8*k +: 8]  = pick_byte();
            high[8*k +: 8] = pick_byte();
         end
         wild = ($urandom_range(0, 3) == 0) ? PATTERN_LIMIT'($urandom_range(0, 65535))
              : PATTERN_LIMIT'($urandom_range(0, 65535) & $urandom_range(0, 65535)
                               & $urandom_range(0, 65535));
         len  = LENGTH_BITS'($urandom_range(1, PATTERN_LIMIT));
         case (phase)
            0: begin
               low  = '1;
               high = '1;
               wild = '0;
               len  = LENGTH_BITS'(PATTERN_LIMIT);
            end
            1: begin
               low  = '0;
               high = '0;
               wild = '1;
               len  = LENGTH_BITS'(PATTERN_LIMIT);
            end
            2: begin
               wild = '0;
               len  = 5'd1;
            end
            3: len = 5'd0;
            4: len = 5'd17;
            5: len = 5'd31;
            default: ;
         endcase
         apply_config(low, high, wild, len);

         // Hold off the result side while the sender keeps offering bytes
         if (phase == 6) begin
            hold_requests++;
            burst_left = 90;
         end

         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal) begin
            send_region();
            if ($urandom_range(0, 29) == 0) begin
               wait_idle();
            end
         end
      end

      // Drain and let the pipeline settle
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("[wildcard_byte_pattern_scanner] OK");
      end else begin
         $display("[wildcard_byte_pattern_scanner] ERROR");
      end
      $finish;
   end

endmodule
